FILE: rtl/core/interval_allocator_preferred_first_fit_core_macros.svh
// Assertion macros shared by the allocator core.
`ifndef INTERVAL_ALLOCATOR_PREFERRED_FIRST_FIT_CORE_MACROS_SVH
`define INTERVAL_ALLOCATOR_PREFERRED_FIRST_FIT_CORE_MACROS_SVH

// Condition that holds on every clock edge out of reset
`define IAPFF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define IAPFF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle
`define IAPFF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/iapff_pkg.sv
`timescale 1ns / 1ps

package iapff_pkg;

   // Default table depth
   localparam int DEF_MAX_INTERVALS = 256;

   // Field widths
   localparam int IN_W     = 32;
   localparam int OUT_W    = 41;
   localparam int STATUS_W = 2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_PREFERRED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MOVED     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Controls broadcast to every cell of the chain
   typedef struct packed {
      logic rotate;   // every cell takes its right neighbour's entry
      logic insert;   // open a slot at the insert position and fill it
   } cell_ctrl_type;

endpackage

FILE: rtl/core/iapff_cell.sv
`timescale 1ns / 1ps

// One entry of the interval table; part of a rotating chain.
module iapff_cell #(
   parameter int POS_W    = 42,
   parameter int IDX_W    = 8,
   parameter int CELL_IDX = 0
) (
   input  logic                   clock,
   input  iapff_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0]       ins_pos,
   input  logic [POS_W-1:0]       new_start,
   input  logic [POS_W-1:0]       new_end,
   input  logic [POS_W-1:0]       right_start,
   input  logic [POS_W-1:0]       right_end,
   input  logic [POS_W-1:0]       left_start,
   input  logic [POS_W-1:0]       left_end,
   output logic [POS_W-1:0]       entry_start,
   output logic [POS_W-1:0]       entry_end
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [POS_W-1:0] start_ff, start_in;
   logic [POS_W-1:0] end_ff, end_in;

   // Rotate towards the head, or shift right from the insert point
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (ctrl.rotate) begin
         start_in = right_start;
         end_in   = right_end;
      end else if (ctrl.insert && (MY_IDX >= ins_pos)) begin
         if (MY_IDX == ins_pos) begin
            start_in = new_start;
            end_in   = new_end;
         end else begin
            start_in = left_start;
            end_in   = left_end;
         end
      end
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign entry_start = start_ff;
   assign entry_end   = end_ff;

endmodule

FILE: rtl/core/interval_allocator_preferred_first_fit_core.sv
`timescale 1ns / 1ps
// An accepted request is scanned over a full turn of the cell ring, then inserted and answered.
// busy stays high through the scan and the insert, so a new request is taken only once
// busy drops again, with the result beat.
// A rejected request (table full) is answered in the next cycle and leaves busy low.
// Reset (synchronous) empties the table by clearing the entry count; cells keep stale data.
// Results are strobed for one cycle; the receiver cannot stall.
`include "interval_allocator_preferred_first_fit_core_macros.svh"

module interval_allocator_preferred_first_fit_core #(
   parameter int MAX_INTERVALS = iapff_pkg::DEF_MAX_INTERVALS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [iapff_pkg::IN_W-1:0]      req_preferred_start,
   input  logic [iapff_pkg::IN_W-1:0]      req_length,
   output logic                            rsp_valid,
   output logic [iapff_pkg::OUT_W-1:0]     rsp_granted_start,
   output logic [iapff_pkg::OUT_W-1:0]     rsp_granted_end,
   output logic [iapff_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int IDX_W = $clog2(MAX_INTERVALS);
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   // Largest end is below (MAX_INTERVALS + 2) * 2^32
   localparam int POS_W = iapff_pkg::IN_W + 1 + CNT_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_INTERVALS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_INTERVALS);

   // State codes
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_INSERT = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic [POS_W-1:0]       s_ff, s_in;
   logic [POS_W-1:0]       e_ff, e_in;
   logic [iapff_pkg::IN_W-1:0] len_ff, len_in;
   logic                   hit_ff, hit_in;
   logic                   pos_found_ff, pos_found_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic                   gap_found_ff, gap_found_in;
   logic [IDX_W-1:0]       gap_pos_ff, gap_pos_in;
   logic [POS_W-1:0]       gap_start_ff, gap_start_in;
   logic [POS_W-1:0]       prev_end_ff, prev_end_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [iapff_pkg::OUT_W-1:0]    rsp_start_ff, rsp_start_in;
   logic [iapff_pkg::OUT_W-1:0]    rsp_end_ff, rsp_end_in;
   logic [iapff_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                      accept;
   logic                      full;
   logic [iapff_pkg::IN_W-1:0] len_adj;
   logic                      head_valid;
   logic [POS_W:0]            gap_limit;
   logic [POS_W-1:0]          fin_start;
   logic [POS_W-1:0]          fin_end;
   logic [IDX_W-1:0]          fin_pos;
   logic [iapff_pkg::STATUS_W-1:0] fin_status;
   iapff_pkg::cell_ctrl_type  cell_ctrl;

   logic [POS_W-1:0] cell_start [MAX_INTERVALS];
   logic [POS_W-1:0] cell_end   [MAX_INTERVALS];

   assign accept  = start && !busy;
   assign full    = (count_ff == FULL_CNT);
   assign len_adj = (req_length == '0) ? iapff_pkg::IN_W'(1) : req_length;

   // Head of the ring holds entry scan_ff during the scan
   assign head_valid = (CNT_W'(scan_ff) < count_ff);
   assign gap_limit  = {1'b0, prev_end_ff} + (POS_W + 1)'(len_ff);

   // Final choice of grant, made in the insert cycle
   always_comb begin
      if (!hit_ff) begin
         fin_start  = s_ff;
         fin_end    = e_ff;
         fin_pos    = pos_found_ff ? pos_ff : IDX_W'(count_ff);
         fin_status = iapff_pkg::STATUS_PREFERRED;
      end else begin
         fin_start  = gap_found_ff ? gap_start_ff : (prev_end_ff + POS_W'(1));
         fin_end    = fin_start + POS_W'(len_ff) - POS_W'(1);
         fin_pos    = gap_found_ff ? gap_pos_ff : IDX_W'(count_ff);
         fin_status = iapff_pkg::STATUS_MOVED;
      end
   end

   // Sequencer: refuse a request on a full table, else scan the ring once, then insert and answer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      len_in        = len_ff;
      hit_in        = hit_ff;
      pos_found_in  = pos_found_ff;
      pos_in        = pos_ff;
      gap_found_in  = gap_found_ff;
      gap_pos_in    = gap_pos_ff;
      gap_start_in  = gap_start_ff;
      prev_end_in   = prev_end_ff;
      rsp_valid_in  = 1'b0;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_status_in = rsp_status_ff;
      cell_ctrl     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_start_in  = '0;
                  rsp_end_in    = '0;
                  rsp_status_in = iapff_pkg::STATUS_FULL;
               end else begin
                  s_in         = POS_W'(req_preferred_start);
                  e_in         = POS_W'(req_preferred_start) + POS_W'(len_adj) - POS_W'(1);
                  len_in       = len_adj;
                  hit_in       = (req_preferred_start == '0);
                  pos_found_in = 1'b0;
                  gap_found_in = 1'b0;
                  prev_end_in  = '0;
                  scan_in      = '0;
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cell_ctrl.rotate = 1'b1;
            if (head_valid) begin
               if ((s_ff <= cell_end[0]) && (cell_start[0] <= e_ff)) begin
                  hit_in = 1'b1;
               end
               if (!pos_found_ff && (cell_start[0] > s_ff)) begin
                  pos_found_in = 1'b1;
                  pos_in       = scan_ff;
               end
               if (!gap_found_ff && ({1'b0, cell_start[0]} > gap_limit)) begin
                  gap_found_in = 1'b1;
                  gap_pos_in   = scan_ff;
                  gap_start_in = prev_end_ff + POS_W'(1);
               end
               prev_end_in = cell_end[0];
            end
            scan_in = scan_ff + IDX_W'(1);
            if (scan_ff == LAST_IDX) begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            cell_ctrl.insert = 1'b1;
            count_in      = count_ff + CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_start_in  = iapff_pkg::OUT_W'(fin_start);
            rsp_end_in    = iapff_pkg::OUT_W'(fin_end);
            rsp_status_in = fin_status;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      s_ff          <= s_in;
      e_ff          <= e_in;
      len_ff        <= len_in;
      hit_ff        <= hit_in;
      pos_found_ff  <= pos_found_in;
      pos_ff        <= pos_in;
      gap_found_ff  <= gap_found_in;
      gap_pos_ff    <= gap_pos_in;
      gap_start_ff  <= gap_start_in;
      prev_end_ff   <= prev_end_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Ring of table cells
   for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
      iapff_cell #(
         .POS_W    (POS_W),
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .ins_pos     (fin_pos),
         .new_start   (fin_start),
         .new_end     (fin_end),
         .right_start (cell_start[(i + 1) % MAX_INTERVALS]),
         .right_end   (cell_end[(i + 1) % MAX_INTERVALS]),
         .left_start  (cell_start[(i + MAX_INTERVALS - 1) % MAX_INTERVALS]),
         .left_end    (cell_end[(i + MAX_INTERVALS - 1) % MAX_INTERVALS]),
         .entry_start (cell_start[i]),
         .entry_end   (cell_end[i])
      );
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_start = rsp_start_ff;
   assign rsp_granted_end   = rsp_end_ff;
   assign rsp_status        = rsp_status_ff;

   // Checks
   `IAPFF_ASSERT_ALWAYS(a_count_bound, count_ff <= FULL_CNT,
      "entry count beyond table depth")
   `IAPFF_ASSERT_NEXT(a_insert_count, state_ff == S_INSERT,
      count_ff == $past(count_ff) + CNT_W'(1), "insert did not add one entry")
   `IAPFF_ASSERT_NEXT(a_accept_scan, accept && !full,
      state_ff == S_SCAN && scan_ff == '0, "accepted request did not start a scan")
   `IAPFF_ASSERT_SAME(a_rsp_source, rsp_valid_ff,
      $past(state_ff == S_INSERT) || $past(accept && full), "result beat without cause")
   `IAPFF_ASSERT_SAME(a_reject_zero, rsp_valid_ff && rsp_status_ff == iapff_pkg::STATUS_FULL,
      rsp_start_ff == '0 && rsp_end_ff == '0, "rejected beat carries a grant")

endmodule

FILE: dv/interval_allocator_checker.sv
`timescale 1ns / 1ps

// Watches the request and result channels of the allocator core, keeps its own
// copy of the granted-interval table and checks every result beat in order.
module interval_allocator_checker #(
   parameter int MAX_INTERVALS = iapff_pkg::DEF_MAX_INTERVALS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [iapff_pkg::IN_W-1:0]      req_preferred_start,
   input  logic [iapff_pkg::IN_W-1:0]      req_length,
   input  logic                            rsp_valid,
   input  logic [iapff_pkg::OUT_W-1:0]     rsp_granted_start,
   input  logic [iapff_pkg::OUT_W-1:0]     rsp_granted_end,
   input  logic [iapff_pkg::STATUS_W-1:0]  rsp_status,
   output int                              fail_count,
   output int                              pending,
   output int                              n_preferred,
   output int                              n_moved,
   output int                              n_full
);

   typedef struct packed {
      logic [iapff_pkg::OUT_W-1:0]    lo_pos;
      logic [iapff_pkg::OUT_W-1:0]    hi_pos;
      logic [iapff_pkg::STATUS_W-1:0] status;
   } grant_type;

   // Shadow table of granted spans, sorted by start; [0, 0] is implicit
   logic [63:0] span_lo [MAX_INTERVALS];
   logic [63:0] span_hi [MAX_INTERVALS];
   int          span_count = 0;

   grant_type grants_due [$];
   int        errors = 0;
   int        tally_pref = 0;
   int        tally_moved = 0;
   int        tally_full = 0;

   // Works out the grant for one request and enters it in the shadow table
   function automatic grant_type allocate(input logic [iapff_pkg::IN_W-1:0] pref_in,
                                          input logic [iapff_pkg::IN_W-1:0] len_in);
      logic [63:0] len;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] prev_hi;
      int          slot;
      bit          clash;
      grant_type   g;
      len = (len_in == '0) ? 64'd1 : {32'd0, len_in};
      if (span_count >= MAX_INTERVALS) begin
         g.lo_pos = '0;
         g.hi_pos = '0;
         g.status = iapff_pkg::STATUS_FULL;
         return g;
      end
      lo = {32'd0, pref_in};
      hi = lo + len - 64'd1;
      // overlap with any taken span, the implicit one at zero included
      clash = (lo == 64'd0);
      for (int k = 0; k < span_count && !clash; k++) begin
         if (lo <= span_hi[k] && span_lo[k] <= hi) clash = 1'b1;
      end
      slot = span_count;
      if (!clash) begin
         for (int k = 0; k < span_count; k++) begin
            if (span_lo[k] > lo) begin
               slot = k;
               break;
            end
         end
         g.status = iapff_pkg::STATUS_PREFERRED;
      end else begin
         // first gap that holds the length, else just past the last span
         lo = (span_count == 0) ? 64'd1 : span_hi[span_count-1] + 64'd1;
         for (int k = 0; k < span_count; k++) begin
            prev_hi = (k == 0) ? 64'd0 : span_hi[k-1];
            if (span_lo[k] > prev_hi && span_lo[k] - prev_hi - 64'd1 >= len) begin
               slot = k;
               lo = prev_hi + 64'd1;
               break;
            end
         end
         hi = lo + len - 64'd1;
         g.status = iapff_pkg::STATUS_MOVED;
      end
      for (int k = span_count; k > slot; k--) begin
         span_lo[k] = span_lo[k-1];
         span_hi[k] = span_hi[k-1];
      end
      span_lo[slot] = lo;
      span_hi[slot] = hi;
      span_count++;
      g.lo_pos = lo[iapff_pkg::OUT_W-1:0];
      g.hi_pos = hi[iapff_pkg::OUT_W-1:0];
      return g;
   endfunction

   function automatic void report(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
   endfunction

   always @(posedge clock) begin : watch
      grant_type want;
      grant_type got;
      if (reset) begin
         span_count = 0;
         grants_due.delete();
      end else begin
         // result beat against the oldest outstanding grant
         if (rsp_valid) begin
            got.lo_pos = rsp_granted_start;
            got.hi_pos = rsp_granted_end;
            got.status = rsp_status;
            if (grants_due.size() == 0) begin
               report("unexpected result (start)", 64'd0, {23'd0, got.lo_pos});
            end else begin
               want = grants_due.pop_front();
               if (got.lo_pos !== want.lo_pos)
                  report("granted_start", {23'd0, want.lo_pos}, {23'd0, got.lo_pos});
               if (got.hi_pos !== want.hi_pos)
                  report("granted_end", {23'd0, want.hi_pos}, {23'd0, got.hi_pos});
               if (got.status !== want.status)
                  report("status", {62'd0, want.status}, {62'd0, got.status});
            end
         end
         // request beat
         if (start && !busy) begin
            want = allocate(req_preferred_start, req_length);
            grants_due = {grants_due, want};
            case (want.status)
               iapff_pkg::STATUS_PREFERRED: tally_pref++;
               iapff_pkg::STATUS_MOVED:     tally_moved++;
               default:                     tally_full++;
            endcase
         end
      end
      pending     <= grants_due.size();
      fail_count  <= errors;
      n_preferred <= tally_pref;
      n_moved     <= tally_moved;
      n_full      <= tally_full;
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int TABLE_DEPTH  = iapff_pkg::DEF_MAX_INTERVALS;
   localparam int ITEMS        = 1350;
   localparam int N_DIRECTED   = 22;
   localparam int PHASE_LEN    = 40;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [iapff_pkg::IN_W-1:0]     req_preferred_start;
   logic [iapff_pkg::IN_W-1:0]     req_length;
   logic                           rsp_valid;
   logic [iapff_pkg::OUT_W-1:0]    rsp_granted_start;
   logic [iapff_pkg::OUT_W-1:0]    rsp_granted_end;
   logic [iapff_pkg::STATUS_W-1:0] rsp_status;

   int fail_count;
   int pending;
   int n_preferred;
   int n_moved;
   int n_full;
   int quiet_cycles = 0;

   // Sender idle chance per phase: none, heavy, none, moderate
   int idle_pct [4] = '{0, 55, 0, 34};

   // Directed requests: zero start, zero length, adjacency, gaps, field extremes
   logic [iapff_pkg::IN_W-1:0] dir_pref [N_DIRECTED] = '{
      32'd0, 32'd1, 32'd10, 32'd3, 32'd12, 32'd100, 32'd101, 32'd99,
      32'd50, 32'd55, 32'd0, 32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFE, 32'd5, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000,
      32'h7FFF_FFFF, 32'd200, 32'd1000
   };
   logic [iapff_pkg::IN_W-1:0] dir_len [N_DIRECTED] = '{
      32'd1, 32'd1, 32'd5, 32'd0, 32'd3, 32'd1, 32'd1, 32'd1,
      32'd20, 32'd10, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'd1,
      32'd1, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1,
      32'd2, 32'd0, 32'h0000_1000
   };

   interval_allocator_preferred_first_fit_core #(
      .MAX_INTERVALS(TABLE_DEPTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_preferred_start (req_preferred_start),
      .req_length          (req_length),
      .rsp_valid           (rsp_valid),
      .rsp_granted_start   (rsp_granted_start),
      .rsp_granted_end     (rsp_granted_end),
      .rsp_status          (rsp_status)
   );

   interval_allocator_checker #(
      .MAX_INTERVALS(TABLE_DEPTH)
   ) checker_i (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_preferred_start (req_preferred_start),
      .req_length          (req_length),
      .rsp_valid           (rsp_valid),
      .rsp_granted_start   (rsp_granted_start),
      .rsp_granted_end     (rsp_granted_end),
      .rsp_status          (rsp_status),
      .fail_count          (fail_count),
      .pending             (pending),
      .n_preferred         (n_preferred),
      .n_moved             (n_moved),
      .n_full              (n_full)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: too long without a request or result beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [iapff_pkg::IN_W-1:0] pref;
      logic [iapff_pkg::IN_W-1:0] len;
      int                         gap;
      reset               <= 1'b1;
      start               <= 1'b0;
      req_preferred_start <= '0;
      req_length          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < ITEMS; i++) begin
         if (i < N_DIRECTED) begin
            pref = dir_pref[i];
            len  = dir_len[i];
         end else begin
            // mostly a crowded low region so that overlaps and gap fits happen
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  pref = $urandom_range(0, 4000);
                  len  = $urandom_range(0, 48);
               end
               6: begin
                  pref = $urandom;
                  len  = $urandom;
               end
               7: begin
                  pref = $urandom;
                  len  = $urandom_range(0, 16);
               end
               8: begin
                  pref = $urandom_range(0, 4000);
                  len  = $urandom;
               end
               default: begin
                  pref = ($urandom_range(0, 1) == 1) ? '0 :
                         iapff_pkg::IN_W'($urandom_range(1, 64));
                  len  = $urandom_range(0, 3);
               end
            endcase
            // sender gap, long enough at times to land anywhere in the walk
            if ($urandom_range(0, 99) < idle_pct[(i / PHASE_LEN) % 4]) begin
               start <= 1'b0;
               if ($urandom_range(0, 1) == 1)
                  gap = $urandom_range(1, 8);
               else
                  gap = $urandom_range(1, TABLE_DEPTH + 40);
               repeat (gap) @(posedge clock);
            end
         end
         req_preferred_start <= pref;
         req_length          <= len;
         start               <= 1'b1;
         // request beat taken at the edge where busy is low
         do @(posedge clock); while (busy);
      end
      start <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d granted as asked, %0d moved, %0d refused on a full table",
               ITEMS, n_preferred, n_moved, n_full);
      $display("Sender gaps varied over %0d-request phases; table depth %0d",
               PHASE_LEN, TABLE_DEPTH);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
